// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers for the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clk edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen at a rising clk edge outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- hw/rtl/lmfsw_pkg.sv -----
// ----------------------------------------------------------------------------
// lmfsw_pkg
// Shared types and constants of the two-wire LED matrix frame writer.
// ----------------------------------------------------------------------------
package lmfsw_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_ADDRESS_COMMAND    = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BRIGHTNESS_COMMAND = 8'd1;

    localparam logic [CFG_DATA_W-1:0] ADDRESS_RESET    = 8'hC0;
    localparam logic [CFG_DATA_W-1:0] BRIGHTNESS_RESET = 8'h8A;

    // A run never returns more pin writes than this
    localparam int MAX_RESULTS = 60;
    localparam int RUN_CNT_W   = 6;

    // Line levels right after one pin write, plus the last-of-run mark
    typedef struct packed {
        logic clock;
        logic data;
        logic last;
    } pin_write_t;

endpackage

// ----- hw/rtl/lmfsw_seq.sv -----
// ----------------------------------------------------------------------------
// lmfsw_seq
// Pin write sequencer: one bus write per cycle while wr_ready is high, for the byte it holds.
// ----------------------------------------------------------------------------
module lmfsw_seq
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [7:0]            in_byte,
    input  logic                  in_first,
    input  logic                  in_last,
    input  logic [7:0]            address_command,
    input  logic [7:0]            brightness_command,
    output logic                  wr_valid,
    input  logic                  wr_ready,
    output lmfsw_pkg::pin_write_t wr
);

    typedef enum logic [2:0] {
        PH_START,
        PH_ADDR,
        PH_DATA,
        PH_STOP1,
        PH_START2,
        PH_BRIGHT,
        PH_STOP2
    } phase_t;

    localparam logic [lmfsw_pkg::RUN_CNT_W-1:0] CNT_CAP =
        lmfsw_pkg::RUN_CNT_W'(lmfsw_pkg::MAX_RESULTS - 1);

    logic                              busy_reg;
    phase_t                            phase_reg;
    phase_t                            phase_next;
    logic [1:0]                        sub_reg;
    logic [2:0]                        bit_reg;
    logic [lmfsw_pkg::RUN_CNT_W-1:0]   count_reg;
    logic [7:0]                        byte_reg;
    logic                              last_reg;
    logic                              clk_pin_reg;
    logic                              dat_pin_reg;

    logic       cond_phase;
    logic [7:0] cur_value;
    logic       set_clock;
    logic       level;
    logic       seg_end;
    logic       natural_final;
    logic       cap_hit;
    logic       final_step;
    logic       advance;
    logic       accept;

    always_comb
    begin
        cond_phase = 1'b0;
        cur_value  = byte_reg;
        phase_next = PH_START;
        set_clock  = (sub_reg != 2'd1);
        level      = (sub_reg == 2'd1) ? cur_value[bit_reg] : (sub_reg == 2'd2);
        unique case (phase_reg)
            PH_START, PH_START2:
            begin
                cond_phase = 1'b1;
                set_clock  = ~sub_reg[0];
                level      = sub_reg[0] ^ sub_reg[1];
                phase_next = (phase_reg == PH_START) ? PH_ADDR : PH_BRIGHT;
            end
            PH_STOP1, PH_STOP2:
            begin
                cond_phase = 1'b1;
                set_clock  = ~sub_reg[0];
                level      = sub_reg[1];
                phase_next = (phase_reg == PH_STOP1) ? PH_START2 : PH_START;
            end
            PH_ADDR:
            begin
                cur_value  = address_command;
                level      = (sub_reg == 2'd1) ? cur_value[bit_reg] : (sub_reg == 2'd2);
                phase_next = PH_DATA;
            end
            PH_BRIGHT:
            begin
                cur_value  = brightness_command;
                level      = (sub_reg == 2'd1) ? cur_value[bit_reg] : (sub_reg == 2'd2);
                phase_next = PH_STOP2;
            end
            PH_DATA:
            begin
                phase_next = PH_STOP1;
            end
            default:
            begin
                phase_next = PH_START;
            end
        endcase
    end

    assign seg_end       = cond_phase ? (sub_reg == 2'd3)
                                      : ((sub_reg == 2'd2) && (bit_reg == 3'd7));
    assign natural_final = seg_end && (((phase_reg == PH_DATA) && !last_reg)
                                       || (phase_reg == PH_STOP2));
    assign cap_hit       = (count_reg == CNT_CAP);
    assign final_step    = natural_final || cap_hit;

    assign wr_valid  = busy_reg;
    assign advance   = busy_reg && wr_ready;
    assign in_ready  = !busy_reg || (advance && final_step);
    assign accept    = in_valid && in_ready;

    assign wr.clock = set_clock ? level : clk_pin_reg;
    assign wr.data  = set_clock ? dat_pin_reg : level;
    assign wr.last  = final_step;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            phase_reg   <= PH_START;
            sub_reg     <= 2'd0;
            bit_reg     <= 3'd0;
            count_reg   <= '0;
            byte_reg    <= 8'd0;
            last_reg    <= 1'b0;
            clk_pin_reg <= 1'b0;
            dat_pin_reg <= 1'b0;
        end
        else
        begin
            // Pins follow every issued write
            if (advance)
            begin
                if (cap_hit && !natural_final)
                begin
                    // Dropped tail of a capped run ends in a stop: both lines high
                    clk_pin_reg <= 1'b1;
                    dat_pin_reg <= 1'b1;
                end
                else if (set_clock)
                begin
                    clk_pin_reg <= level;
                end
                else
                begin
                    dat_pin_reg <= level;
                end
            end

            if (accept)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= in_first ? PH_START : PH_DATA;
                sub_reg   <= 2'd0;
                bit_reg   <= 3'd0;
                count_reg <= '0;
                byte_reg  <= in_byte;
                last_reg  <= in_last;
            end
            else if (advance && final_step)
            begin
                busy_reg <= 1'b0;
            end
            else if (advance)
            begin
                count_reg <= count_reg + 1'b1;
                if (seg_end)
                begin
                    phase_reg <= phase_next;
                    sub_reg   <= 2'd0;
                    bit_reg   <= 3'd0;
                end
                else if (!cond_phase && (sub_reg == 2'd2))
                begin
                    sub_reg <= 2'd0;
                    bit_reg <= bit_reg + 1'b1;
                end
                else
                begin
                    sub_reg <= sub_reg + 1'b1;
                end
            end
        end
    end

endmodule

// ----- hw/rtl/lmfsw_out.sv -----
// ----------------------------------------------------------------------------
// lmfsw_out
// Result register between the sequencer and the output channel.
// ----------------------------------------------------------------------------
module lmfsw_out
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_valid,
    output logic                  wr_ready,
    input  lmfsw_pkg::pin_write_t wr,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lmfsw_pkg::pin_write_t out_wr
);

    logic                  valid_reg;
    lmfsw_pkg::pin_write_t data_reg;

    assign wr_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_wr    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (wr_ready)
        begin
            valid_reg <= wr_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ready && wr_valid)
        begin
            data_reg <= wr;
        end
    end

endmodule

// ----- hw/rtl/led_matrix_frame_serial_writer_core.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_serial_writer_core
// Frames display bytes into the pin writes of a two-wire LED driver bus.
// ----------------------------------------------------------------------------
// Each accepted display byte becomes a run of pin writes, one result per
// cycle unless stalled, each giving the clock and data levels right after
// that write. A middle byte of the frame gives 24 writes (8 bits, three
// writes per bit, LSB first). The first byte of a frame adds a start and the
// address command (52 writes); the last byte adds stop, start, brightness
// command and stop (60 writes). With a one-byte frame the run is cut after
// 60 writes, the 60th marked last_of_run, while the lines still end as after
// the full run. The sequencer issues the writes; the next byte is taken in
// the cycle the previous run's final write is issued, and a result register
// lets that happen while the output side stalls if the register is empty.
// Write address_command and brightness_command only between runs.
module led_matrix_frame_serial_writer_core
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    // byte request channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [7:0]                        display_byte,
    // pin write channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              clock_level,
    output logic                              data_level,
    output logic                              last_of_run,
    // configuration
    input  logic                              cfg_we,
    input  logic [lmfsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lmfsw_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = (FRAME_BYTES > 1) ? $clog2(FRAME_BYTES) : 1;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);

    logic [POS_W-1:0]              pos_reg;
    logic [7:0]                    address_reg;
    logic [7:0]                    brightness_reg;
    logic                          seq_in_ready;
    logic                          first_byte;
    logic                          last_byte;
    logic                          wr_valid;
    logic                          wr_ready;
    lmfsw_pkg::pin_write_t         wr;
    lmfsw_pkg::pin_write_t         out_wr;

    // Frame position decides whether the framing commands wrap this byte
    assign first_byte = (pos_reg == '0);
    assign last_byte  = (pos_reg == POS_LAST);
    assign in_ready   = seq_in_ready;

    // Advance the frame position on every accepted request, wrap after the last
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
        end
        else if (in_valid && seq_in_ready)
        begin
            pos_reg <= last_byte ? '0 : pos_reg + 1'b1;
        end
    end

    // Command registers; drop writes to any other index
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            address_reg    <= lmfsw_pkg::ADDRESS_RESET;
            brightness_reg <= lmfsw_pkg::BRIGHTNESS_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == lmfsw_pkg::REG_ADDRESS_COMMAND)
            begin
                address_reg <= cfg_data;
            end
            else if (cfg_index == lmfsw_pkg::REG_BRIGHTNESS_COMMAND)
            begin
                brightness_reg <= cfg_data;
            end
        end
    end

    lmfsw_seq u_seq
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .in_valid           (in_valid),
        .in_ready           (seq_in_ready),
        .in_byte            (display_byte),
        .in_first           (first_byte),
        .in_last            (last_byte),
        .address_command    (address_reg),
        .brightness_command (brightness_reg),
        .wr_valid           (wr_valid),
        .wr_ready           (wr_ready),
        .wr                 (wr)
    );

    // Hold each write until the output side takes it
    lmfsw_out u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr_valid  (wr_valid),
        .wr_ready  (wr_ready),
        .wr        (wr),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_wr    (out_wr)
    );

    assign clock_level = out_wr.clock;
    assign data_level  = out_wr.data;
    assign last_of_run = out_wr.last;

endmodule

// ----- hw/rtl/lmfsw_checker.sv -----
// ----------------------------------------------------------------------------
// lmfsw_checker
// Port-level checks of the frame writer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lmfsw_checker
#(
    parameter int FRAME_BYTES = 16
)
(
    input logic clk,
    input logic rst_n,
    input logic out_valid,
    input logic out_ready,
    input logic clock_level,
    input logic data_level,
    input logic last_of_run
);

    localparam logic [lmfsw_pkg::RUN_CNT_W-1:0] CNT_CAP =
        lmfsw_pkg::RUN_CNT_W'(lmfsw_pkg::MAX_RESULTS - 1);

    logic                            out_acc;
    logic                            have_prev_reg;
    logic                            prev_clk_reg;
    logic                            prev_dat_reg;
    logic [lmfsw_pkg::RUN_CNT_W-1:0] run_cnt_reg;

    assign out_acc = out_valid && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_prev_reg <= 1'b0;
            prev_clk_reg  <= 1'b0;
            prev_dat_reg  <= 1'b0;
            run_cnt_reg   <= '0;
        end
        else if (out_acc)
        begin
            have_prev_reg <= 1'b1;
            prev_clk_reg  <= clock_level;
            prev_dat_reg  <= data_level;
            run_cnt_reg   <= last_of_run ? '0 : run_cnt_reg + 1'b1;
        end
    end

    `ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable({clock_level, data_level, last_of_run}), "stalled pin write changed")
    `ASSERT_CLK(a_one_line, out_acc && have_prev_reg && (FRAME_BYTES > 1) |-> $countones({clock_level ^ prev_clk_reg, data_level ^ prev_dat_reg}) <= 1, "two lines changed in one write")
    `ASSERT_NEVER(a_run_cap, out_acc && (run_cnt_reg == CNT_CAP) && !last_of_run, "run longer than the result limit")
    `ASSERT_NEVER(a_last_clk, out_acc && last_of_run && !clock_level, "run ended with clock low")

endmodule

bind led_matrix_frame_serial_writer_core lmfsw_checker #(.FRAME_BYTES(FRAME_BYTES)) u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .clock_level (clock_level),
    .data_level  (data_level),
    .last_of_run (last_of_run)
);

// ----- dv/frame_write_checker.sv -----
// ----------------------------------------------------------------------------
// frame_write_checker
// Watches the byte and pin write channels of the frame writer, predicts the
// pin writes each accepted byte must cause and compares them in order.
// ----------------------------------------------------------------------------
module frame_write_checker
#(
    parameter int FRAME_BYTES = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    input  logic                              in_ready,
    input  logic [7:0]                        display_byte,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              clock_level,
    input  logic                              data_level,
    input  logic                              last_of_run,
    input  logic                              cfg_we,
    input  logic [lmfsw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lmfsw_pkg::CFG_DATA_W-1:0]  cfg_data,
    output int                                fail_count,
    output int                                pending_writes
);

    typedef enum logic {LINE_CLOCK, LINE_DATA} bus_line_t;

    localparam int PRINT_CAP = 30;

    lmfsw_pkg::pin_write_t expected_writes[$];
    logic [7:0]            address_cmd;
    logic [7:0]            brightness_cmd;
    int unsigned           frame_pos;
    logic                  clock_line;
    logic                  data_pin;
    int                    run_len;
    int                    writes_seen;

    task automatic flag_mismatch(input string msg);
        if (fail_count < PRINT_CAP)
            $display("MISMATCH at write %0d: %s", writes_seen, msg);
        fail_count++;
    endtask

    // One pin write; only the first MAX_RESULTS of a run are returned
    function automatic void pin_write(input bus_line_t line, input logic level);
        if (line == LINE_DATA)
            data_pin = level;
        else
            clock_line = level;
        if (run_len < lmfsw_pkg::MAX_RESULTS) begin
            expected_writes.push_back('{clock: clock_line, data: data_pin, last: 1'b0});
            run_len++;
        end
    endfunction

    function automatic void start_condition();
        pin_write(LINE_CLOCK, 1'b0);
        pin_write(LINE_DATA,  1'b1);
        pin_write(LINE_CLOCK, 1'b1);
        pin_write(LINE_DATA,  1'b0);
    endfunction

    function automatic void stop_condition();
        pin_write(LINE_CLOCK, 1'b0);
        pin_write(LINE_DATA,  1'b0);
        pin_write(LINE_CLOCK, 1'b1);
        pin_write(LINE_DATA,  1'b1);
    endfunction

    function automatic void shift_byte(input logic [7:0] value);
        for (int b = 0; b < 8; b++) begin
            pin_write(LINE_CLOCK, 1'b0);
            pin_write(LINE_DATA,  value[b]);
            pin_write(LINE_CLOCK, 1'b1);
        end
    endfunction

    function automatic void frame_display_byte(input logic [7:0] value);
        run_len = 0;
        if (frame_pos >= FRAME_BYTES)
            frame_pos = 0;
        if (frame_pos == 0) begin
            start_condition();
            shift_byte(address_cmd);
        end
        shift_byte(value);
        if (frame_pos + 1 >= FRAME_BYTES) begin
            stop_condition();
            start_condition();
            shift_byte(brightness_cmd);
            stop_condition();
            frame_pos = 0;
        end
        else begin
            frame_pos++;
        end
        expected_writes[expected_writes.size()-1].last = 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lmfsw_pkg::pin_write_t want;
        if (!rst_n) begin
            expected_writes.delete();
            address_cmd    = lmfsw_pkg::ADDRESS_RESET;
            brightness_cmd = lmfsw_pkg::BRIGHTNESS_RESET;
            frame_pos      = 0;
            clock_line     = 1'b0;
            data_pin       = 1'b0;
            run_len        = 0;
            writes_seen    = 0;
            fail_count     = 0;
            pending_writes = 0;
        end
        else begin
            if (cfg_we) begin
                if (cfg_index == lmfsw_pkg::REG_ADDRESS_COMMAND)
                    address_cmd = cfg_data;
                else if (cfg_index == lmfsw_pkg::REG_BRIGHTNESS_COMMAND)
                    brightness_cmd = cfg_data;
            end
            if (out_valid && out_ready) begin
                if (expected_writes.size() == 0) begin
                    flag_mismatch("pin write with none expected");
                end
                else begin
                    want = expected_writes.pop_front();
                    if (clock_level !== want.clock)
                        flag_mismatch($sformatf("clock_level %b, expected %b",
                                                clock_level, want.clock));
                    if (data_level !== want.data)
                        flag_mismatch($sformatf("data_level %b, expected %b",
                                                data_level, want.data));
                    if (last_of_run !== want.last)
                        flag_mismatch($sformatf("last_of_run %b, expected %b",
                                                last_of_run, want.last));
                end
                writes_seen++;
            end
            if (in_valid && in_ready)
                frame_display_byte(display_byte);
            pending_writes = expected_writes.size();
        end
    end

endmodule

// ----- dv/led_matrix_frame_serial_writer_core_tb.sv -----
// ----------------------------------------------------------------------------
// led_matrix_frame_serial_writer_core_tb
// Feeds display bytes and command settings to the frame writer and lets the
// checker compare every pin write against its own prediction.
// ----------------------------------------------------------------------------
// Stimulus runs in three parts. Right after reset, writes to register
// indexes the block does not decode must leave both commands untouched, so a
// full frame led by edge-case bytes goes out under reset commands. Then come
// random phases: each one waits for the block to drain, programs a new pair
// of commands (all zeros and all ones first, random after) and sends a random
// number of bytes, so frames straddle phase boundaries. The receiver stalls
// at random and once holds off long enough to back up the byte channel.
module led_matrix_frame_serial_writer_core_tb;

    localparam int FRAME_BYTES   = 16;
    localparam int RANDOM_BYTES  = 104;
    localparam int STALL_LIMIT   = 3000;   // cycles with no request moving
    localparam int HOLD_OFF      = 400;    // one long receiver hold-off
    localparam int HOLD_AFTER    = 300;    // pin writes taken before it
    localparam int TAIL_CYCLES   = 64;

    // Register indexes the block must ignore
    localparam logic [lmfsw_pkg::CFG_INDEX_W-1:0] STRAY_INDEX_LOW  = 8'd2;
    localparam logic [lmfsw_pkg::CFG_INDEX_W-1:0] STRAY_INDEX_HIGH = 8'hFF;

    // Byte extremes and walking patterns for the directed frame
    localparam logic [7:0] EDGE_BYTES [8] =
        '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h0F, 8'hF0, 8'hAA, 8'h55};

    logic                              clk          = 1'b0;
    logic                              rst_n        = 1'b0;
    logic                              in_valid     = 1'b0;
    logic                              in_ready;
    logic [7:0]                        display_byte = 8'h00;
    logic                              out_valid;
    logic                              out_ready    = 1'b0;
    logic                              clock_level;
    logic                              data_level;
    logic                              last_of_run;
    logic                              cfg_we       = 1'b0;
    logic [lmfsw_pkg::CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [lmfsw_pkg::CFG_DATA_W-1:0]  cfg_data     = '0;
    int                                fail_count;
    int                                pending_writes;
    int                                idle_cycles  = 0;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    led_matrix_frame_serial_writer_core #(
        .FRAME_BYTES (FRAME_BYTES)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .display_byte (display_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .clock_level  (clock_level),
        .data_level   (data_level),
        .last_of_run  (last_of_run),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    frame_write_checker #(
        .FRAME_BYTES (FRAME_BYTES)
    ) checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .display_byte   (display_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .clock_level    (clock_level),
        .data_level     (data_level),
        .last_of_run    (last_of_run),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .fail_count     (fail_count),
        .pending_writes (pending_writes)
    );

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 4);
        else
            return $urandom_range(10, 60);
    endfunction

    // Offer one byte request, hold it until taken, then maybe idle a while.
    // Leave in_valid high when no gap follows so the next request goes
    // out without a bubble.
    task automatic send_byte(input logic [7:0] value);
        int gap;
        in_valid     <= 1'b1;
        display_byte <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drop the byte channel and wait until every predicted write has come out
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_writes != 0)
            @(negedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Two back-to-back register writes; hold cfg_we across both
    task automatic write_reg_pair(input logic [lmfsw_pkg::CFG_INDEX_W-1:0] idx_a,
                                  input logic [lmfsw_pkg::CFG_DATA_W-1:0]  val_a,
                                  input logic [lmfsw_pkg::CFG_INDEX_W-1:0] idx_b,
                                  input logic [lmfsw_pkg::CFG_DATA_W-1:0]  val_b);
        cfg_we    <= 1'b1;
        cfg_index <= idx_a;
        cfg_data  <= val_a;
        @(posedge clk);
        cfg_index <= idx_b;
        cfg_data  <= val_b;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Sender: reset, directed frame, then random phases
    initial
    begin : sender
        int               sent;
        int               phase;
        int               burst;
        logic [7:0]       addr_cmd;
        logic [7:0]       bright_cmd;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Writes to undecoded indexes must not disturb the reset commands
        write_reg_pair(STRAY_INDEX_LOW, 8'h00, STRAY_INDEX_HIGH, 8'h5A);

        // One full frame under reset commands: edge bytes first, random rest.
        // The last byte wraps the frame position and closes the frame.
        for (int i = 0; i < FRAME_BYTES; i++) begin
            if (i < 8)
                send_byte(EDGE_BYTES[i]);
            else
                send_byte(8'($urandom));
        end
        drain();

        // Random phases; the first two set the command extremes
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_BYTES) begin
            case (phase)
                0:       begin addr_cmd = 8'h00; bright_cmd = 8'hFF; end
                1:       begin addr_cmd = 8'hFF; bright_cmd = 8'h00; end
                default: begin addr_cmd = 8'($urandom); bright_cmd = 8'($urandom); end
            endcase
            write_reg_pair(lmfsw_pkg::REG_ADDRESS_COMMAND, addr_cmd,
                           lmfsw_pkg::REG_BRIGHTNESS_COMMAND, bright_cmd);
            burst = $urandom_range(1, 40);
            if (burst > RANDOM_BYTES - sent)
                burst = RANDOM_BYTES - sent;
            repeat (burst) begin
                send_byte(8'($urandom));
                sent++;
            end
            drain();
            phase++;
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // Receiver: random ready runs and gaps, plus one long hold-off while the
    // sender keeps offering, so the block backs up and stalls byte requests
    initial
    begin : receiver
        int  run;
        int  gap;
        int  taken;
        bit  held;

        taken = 0;
        held  = 1'b0;
        @(posedge clk);
        while (!rst_n)
            @(posedge clk);
        forever begin
            if (!held && taken >= HOLD_AFTER) begin
                held = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_OFF) @(posedge clk);
            end
            run = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 200)
                                              : $urandom_range(1, 12);
            out_ready <= 1'b1;
            repeat (run) begin
                @(posedge clk);
                if (out_valid && out_ready)
                    taken++;
            end
            gap = pick_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    end

    // Watchdog: end the run when no request moves for too long
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

endmodule

// ----- led_matrix_frame_serial_writer_core.f -----
+incdir+hw/rtl
hw/rtl/lmfsw_pkg.sv
hw/rtl/lmfsw_seq.sv
hw/rtl/lmfsw_out.sv
hw/rtl/led_matrix_frame_serial_writer_core.sv
hw/rtl/lmfsw_checker.sv
dv/frame_write_checker.sv
dv/led_matrix_frame_serial_writer_core_tb.sv
